// ===== design/blp_pkg.sv =====
// ---------------------------------------------------------------------------
// blp_pkg: shared types and constants for the battery load protection block
// Register indexes, status codes, reset defaults, field widths and the
// structs that carry stage enables and per-channel trip results.
// ---------------------------------------------------------------------------
package blp_pkg;

   // Field widths
   localparam int ADC_W   = 10;
   localparam int RAW_W   = 18;
   localparam int MAG_W   = 17;
   localparam int LOAD_W  = 16;
   localparam int MV_W    = 15;
   localparam int TIME_W  = 32;
   localparam int DELAY_W = 16;
   localparam int NUM_ADC = 4;

   // Configuration port
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 17;

   localparam logic [CSR_IDX_W-1:0] CSR_CUTOFF   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RECOVERY = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_AC_LIMIT = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_DC_LIMIT = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_TOTAL    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_RETRY    = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_NOISE    = 3'd6;

   // Register reset values
   localparam logic [MV_W-1:0]    CUTOFF_RST   = 15'd9900;
   localparam logic [MV_W-1:0]    RECOVERY_RST = 15'd11600;
   localparam logic [MAG_W-1:0]   AC_LIMIT_RST = 17'd28000;
   localparam logic [MAG_W-1:0]   DC_LIMIT_RST = 17'd15000;
   localparam logic [MAG_W-1:0]   TOTAL_RST    = 17'd30000;
   localparam logic [DELAY_W-1:0] RETRY_RST    = 16'd5000;
   localparam logic [MAG_W-1:0]   NOISE_RST    = 17'd900;

   // Tick status codes
   localparam logic [1:0] STATUS_NORMAL = 2'd0;
   localparam logic [1:0] STATUS_UNDERV = 2'd1;
   localparam logic [1:0] STATUS_HOLD   = 2'd2;

   // Voltage scaling: mv = sum * MV_SCALE / (n * ADC_FULL) + MV_OFFSET
   localparam int MV_SCALE  = 25000;
   localparam int ADC_FULL  = 1023;
   localparam int MV_OFFSET = 100;

   // Divide by 3: exact for values below 2^17
   localparam logic [LOAD_W-1:0] RECIP3 = 16'd43691;
   localparam int RECIP3_SHIFT = 17;

   // Load enables of the four pipeline stages
   typedef struct packed {
      logic s1;
      logic s2;
      logic s3;
      logic s4;
   } pipe_en_type;

   // One channel's outcome before the combined-current check
   typedef struct packed {
      logic              closed;
      logic [TIME_W-1:0] stamp;
      logic [LOAD_W-1:0] load;
   } lane_res_type;

endpackage

// ===== design/blp_volt.sv =====
// ---------------------------------------------------------------------------
// blp_volt: battery voltage pipeline
// Sums the ADC samples, scales by the full-scale voltage and divides by the
// sample span through a reciprocal multiply with a one-step correction.
// ---------------------------------------------------------------------------
module blp_volt
   import blp_pkg::*;
#(
   parameter int SAMPLE_COUNT = 4
) (
   input  logic                          clock,
   input  pipe_en_type                   en,
   input  logic [NUM_ADC-1:0][ADC_W-1:0] samples,
   output logic [MV_W-1:0]               mv
);

   localparam int USED    = (SAMPLE_COUNT > NUM_ADC) ? NUM_ADC : SAMPLE_COUNT;
   localparam int DIV     = USED * ADC_FULL;
   localparam int SUM_W   = 12;
   localparam int X_W     = 27;
   localparam int SHIFT   = 27;
   localparam int MULT_W  = 18;
   localparam logic [MULT_W-1:0] MULT = MULT_W'((2 ** SHIFT) / DIV);
   localparam int PROD_W  = X_W + MULT_W;

   logic [SUM_W-1:0]  sum_c;
   logic [X_W-1:0]    x_in;
   logic [X_W-1:0]    x_s1_ff;
   logic [X_W-1:0]    x_s2_ff;
   logic [PROD_W-1:0] prod_c;
   logic [MV_W-1:0]   q0_s2_ff;
   logic [MV_W-1:0]   q0_s3_ff;
   logic [X_W-1:0]    qd_c;
   logic [X_W-1:0]    rem_s3_ff;
   logic [MV_W-1:0]   mv_ff;

   // Sum of the samples in use
   always_comb begin
      sum_c = '0;
      for (int i = 0; i < USED; i++) begin
         sum_c = sum_c + SUM_W'(samples[i]);
      end
   end

   assign x_in = X_W'(sum_c) * X_W'(MV_SCALE);

   // Stage 1: scaled sum
   always_ff @(posedge clock) begin
      if (en.s1) begin
         x_s1_ff <= x_in;
      end
   end

   // Stage 2: quotient estimate, low by at most one
   assign prod_c = PROD_W'(x_s1_ff) * PROD_W'(MULT);

   always_ff @(posedge clock) begin
      if (en.s2) begin
         x_s2_ff  <= x_s1_ff;
         q0_s2_ff <= prod_c[SHIFT +: MV_W];
      end
   end

   // Stage 3: remainder of the estimate
   assign qd_c = X_W'(q0_s2_ff) * X_W'(DIV);

   always_ff @(posedge clock) begin
      if (en.s3) begin
         q0_s3_ff  <= q0_s2_ff;
         rem_s3_ff <= x_s2_ff - qd_c;
      end
   end

   // Stage 4: correct and add the offset
   always_ff @(posedge clock) begin
      if (en.s4) begin
         mv_ff <= q0_s3_ff + MV_W'(rem_s3_ff >= X_W'(DIV)) + MV_W'(MV_OFFSET);
      end
   end

   assign mv = mv_ff;

endmodule

// ===== design/blp_cond.sv =====
// ---------------------------------------------------------------------------
// blp_cond: load current conditioning lane
// Drops currents at or below the noise floor and divides the rest by three,
// aligned with the voltage pipeline.
// ---------------------------------------------------------------------------
module blp_cond
   import blp_pkg::*;
(
   input  logic              clock,
   input  pipe_en_type       en,
   input  logic [RAW_W-1:0]  raw,
   input  logic [MAG_W-1:0]  noise_floor,
   output logic [LOAD_W-1:0] load
);

   localparam int PROD_W = MAG_W + LOAD_W;

   logic [MAG_W-1:0]  gated_in;
   logic [MAG_W-1:0]  gated_ff;
   logic [PROD_W-1:0] prod_c;
   logic [LOAD_W-1:0] load_s2_ff;
   logic [LOAD_W-1:0] load_s3_ff;
   logic [LOAD_W-1:0] load_s4_ff;

   // Negative values never pass the floor
   assign gated_in = (!raw[RAW_W-1] && (raw[MAG_W-1:0] > noise_floor)) ?
                     raw[MAG_W-1:0] : '0;

   assign prod_c = PROD_W'(gated_ff) * PROD_W'(RECIP3);

   always_ff @(posedge clock) begin
      if (en.s1) begin
         gated_ff <= gated_in;
      end
      if (en.s2) begin
         load_s2_ff <= prod_c[RECIP3_SHIFT +: LOAD_W];
      end
      if (en.s3) begin
         load_s3_ff <= load_s2_ff;
      end
      if (en.s4) begin
         load_s4_ff <= load_s3_ff;
      end
   end

   assign load = load_s4_ff;

endmodule

// ===== design/blp_trip.sv =====
// ---------------------------------------------------------------------------
// blp_trip: per-channel trip and re-arm decision
// Closes an armed relay, trips it on overcurrent and clears the stamp of an
// open relay once the retry delay has elapsed.
// ---------------------------------------------------------------------------
module blp_trip
   import blp_pkg::*;
(
   input  logic               pass,
   input  logic               relay,
   input  logic [TIME_W-1:0]  stamp,
   input  logic [LOAD_W-1:0]  cond_load,
   input  logic [MAG_W-1:0]   limit,
   input  logic [TIME_W-1:0]  now,
   input  logic [DELAY_W-1:0] retry,
   output lane_res_type       res
);

   logic              armed;
   logic              closed_c;
   logic [TIME_W-1:0] stamp_c;
   logic [LOAD_W-1:0] load_c;
   logic [TIME_W-1:0] elapsed_c;

   assign armed = (stamp == '0);

   always_comb begin
      closed_c = relay;
      stamp_c  = stamp;
      load_c   = '0;
      if (pass && armed) begin
         closed_c = 1'b1;
         load_c   = cond_load;
         if (MAG_W'(cond_load) > limit) begin
            closed_c = 1'b0;
            stamp_c  = now;
         end
      end
   end

   // Timeout on wrapping time, also for a trip taken in this tick
   assign elapsed_c = now - stamp_c;

   always_comb begin
      res.closed = closed_c;
      res.load   = load_c;
      res.stamp  = stamp_c;
      if (pass && !closed_c && (elapsed_c >= TIME_W'(retry))) begin
         res.stamp = '0;
      end
   end

endmodule

// ===== design/battery_load_protection.sv =====
// ---------------------------------------------------------------------------
// battery_load_protection: battery undervoltage and load overcurrent guard
// Top level: stage control, configuration registers, relay and stamp state
// and the merge of both load channels.
// ---------------------------------------------------------------------------
// Usage:
//  req_* carries one control tick per transaction (four ADC samples, two raw
//  load currents, the millisecond time). rsp_* returns one result per tick.
//  csr_* writes a configuration register; it is always ready, and writes
//  are expected only while no tick is in flight.
//  Each tick passes the four-stage voltage divide (scale, reciprocal multiply,
//  remainder, correction) and then the output register. Throughput: one tick
//  per cycle while rsp_tready is high; relay and stamp state is updated in
//  the single output stage, so consecutive ticks follow directly.
//  Stall: when rsp_tready is low the output register holds its result and
//  the stages behind it keep filling; req_tready falls once all four stages
//  and the output register are occupied.
//  Reset: synchronous; clears the stage valids, opens both relays, arms both
//  channels and restores all configuration registers to their defaults.
// ---------------------------------------------------------------------------
module battery_load_protection
   import blp_pkg::*;
#(
   parameter int SAMPLE_COUNT = 4
) (
   input  logic                  clock,
   input  logic                  reset,
   // Tick input
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // adc_sample_a[9:0], adc_sample_b[19:10], adc_sample_c[29:20],
   // adc_sample_d[39:30], ac_measured_ma[57:40], dc_measured_ma[75:58],
   // now_ms[107:76], zero fill[111:108]
   input  logic [111:0]          req_tdata,
   // Tick result
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // ac_on[0], dc_on[1], battery_mv[16:2], ac_load_ma[32:17],
   // dc_load_ma[48:33], tick_status[50:49], zero fill[55:51]
   output logic [55:0]           rsp_tdata,
   // Configuration write
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   // Configuration registers
   logic [MV_W-1:0]    cutoff_ff;
   logic [MV_W-1:0]    recovery_ff;
   logic [MAG_W-1:0]   ac_limit_ff;
   logic [MAG_W-1:0]   dc_limit_ff;
   logic [MAG_W-1:0]   total_ff;
   logic [DELAY_W-1:0] retry_ff;
   logic [MAG_W-1:0]   noise_ff;

   // Stage control
   logic        v1_ff, v2_ff, v3_ff, v4_ff, out_valid_ff;
   logic        rdy1, rdy2, rdy3, rdy4, rdy_o;
   logic        adv_o;
   pipe_en_type en;

   // Datapath
   logic [NUM_ADC-1:0][ADC_W-1:0] samples;
   logic [TIME_W-1:0] now_s1_ff, now_s2_ff, now_s3_ff, now_s4_ff;
   logic [MV_W-1:0]   mv_s4;
   logic [LOAD_W-1:0] ac_cond, dc_cond;

   // Channel state
   logic              ac_relay_ff, dc_relay_ff;
   logic              ac_relay_in, dc_relay_in;
   logic [TIME_W-1:0] ac_stamp_ff, dc_stamp_ff;
   logic [TIME_W-1:0] ac_stamp_in, dc_stamp_in;

   // Merge
   logic              both_on, underv, hold_c, pass;
   logic [MAG_W-1:0]  total_sum;
   logic              over_total;
   lane_res_type      ac_res, dc_res;
   logic [LOAD_W-1:0] ac_load_in, dc_load_in;
   logic [1:0]        status_in;

   // Output register
   logic              ac_on_ff, dc_on_ff;
   logic [MV_W-1:0]   mv_out_ff;
   logic [LOAD_W-1:0] ac_load_ff, dc_load_ff;
   logic [1:0]        status_ff;

   // Configuration writes
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cutoff_ff   <= CUTOFF_RST;
         recovery_ff <= RECOVERY_RST;
         ac_limit_ff <= AC_LIMIT_RST;
         dc_limit_ff <= DC_LIMIT_RST;
         total_ff    <= TOTAL_RST;
         retry_ff    <= RETRY_RST;
         noise_ff    <= NOISE_RST;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_CUTOFF:   cutoff_ff   <= csr_data[MV_W-1:0];
            CSR_RECOVERY: recovery_ff <= csr_data[MV_W-1:0];
            CSR_AC_LIMIT: ac_limit_ff <= csr_data[MAG_W-1:0];
            CSR_DC_LIMIT: dc_limit_ff <= csr_data[MAG_W-1:0];
            CSR_TOTAL:    total_ff    <= csr_data[MAG_W-1:0];
            CSR_RETRY:    retry_ff    <= csr_data[DELAY_W-1:0];
            CSR_NOISE:    noise_ff    <= csr_data[MAG_W-1:0];
            default: ;
         endcase
      end
   end

   // Stage ready chain: a stage loads when empty or when it moves on
   assign rdy_o = !out_valid_ff || rsp_tready;
   assign rdy4  = !v4_ff || rdy_o;
   assign rdy3  = !v3_ff || rdy4;
   assign rdy2  = !v2_ff || rdy3;
   assign rdy1  = !v1_ff || rdy2;
   assign adv_o = v4_ff && rdy_o;

   assign req_tready = rdy1;
   assign en.s1 = rdy1;
   assign en.s2 = rdy2;
   assign en.s3 = rdy3;
   assign en.s4 = rdy4;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         v4_ff        <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (rdy1) v1_ff <= req_tvalid;
         if (rdy2) v2_ff <= v1_ff;
         if (rdy3) v3_ff <= v2_ff;
         if (rdy4) v4_ff <= v3_ff;
         if (rdy_o) out_valid_ff <= v4_ff;
      end
   end

   // Time stamp follows the tick down the stages
   always_ff @(posedge clock) begin
      if (rdy1) now_s1_ff <= req_tdata[107:76];
      if (rdy2) now_s2_ff <= now_s1_ff;
      if (rdy3) now_s3_ff <= now_s2_ff;
      if (rdy4) now_s4_ff <= now_s3_ff;
   end

   // Voltage and current lanes
   assign samples[0] = req_tdata[9:0];
   assign samples[1] = req_tdata[19:10];
   assign samples[2] = req_tdata[29:20];
   assign samples[3] = req_tdata[39:30];

   blp_volt #(
      .SAMPLE_COUNT(SAMPLE_COUNT)
   ) u_volt (
      .clock   (clock),
      .en      (en),
      .samples (samples),
      .mv      (mv_s4)
   );

   blp_cond u_ac_cond (
      .clock       (clock),
      .en          (en),
      .raw         (req_tdata[57:40]),
      .noise_floor (noise_ff),
      .load        (ac_cond)
   );

   blp_cond u_dc_cond (
      .clock       (clock),
      .en          (en),
      .raw         (req_tdata[75:58]),
      .noise_floor (noise_ff),
      .load        (dc_cond)
   );

   // Battery level decision
   assign both_on = ac_relay_ff && dc_relay_ff;
   assign underv  = both_on && (mv_s4 <= cutoff_ff);
   assign hold_c  = !both_on && (mv_s4 < recovery_ff);
   assign pass    = !underv && !hold_c;

   blp_trip u_ac_trip (
      .pass      (pass),
      .relay     (ac_relay_ff),
      .stamp     (ac_stamp_ff),
      .cond_load (ac_cond),
      .limit     (ac_limit_ff),
      .now       (now_s4_ff),
      .retry     (retry_ff),
      .res       (ac_res)
   );

   blp_trip u_dc_trip (
      .pass      (pass),
      .relay     (dc_relay_ff),
      .stamp     (dc_stamp_ff),
      .cond_load (dc_cond),
      .limit     (dc_limit_ff),
      .now       (now_s4_ff),
      .retry     (retry_ff),
      .res       (dc_res)
   );

   // Merge both channels, combined overload trips both
   assign total_sum  = MAG_W'(ac_res.load) + MAG_W'(dc_res.load);
   assign over_total = total_sum >= total_ff;

   always_comb begin
      ac_relay_in = ac_relay_ff;
      dc_relay_in = dc_relay_ff;
      ac_stamp_in = ac_stamp_ff;
      dc_stamp_in = dc_stamp_ff;
      ac_load_in  = ac_res.load;
      dc_load_in  = dc_res.load;
      status_in   = STATUS_NORMAL;
      if (underv) begin
         ac_relay_in = 1'b0;
         dc_relay_in = 1'b0;
         status_in   = STATUS_UNDERV;
      end else if (hold_c) begin
         status_in   = STATUS_HOLD;
      end else begin
         ac_relay_in = ac_res.closed;
         dc_relay_in = dc_res.closed;
         ac_stamp_in = ac_res.stamp;
         dc_stamp_in = dc_res.stamp;
         if (over_total) begin
            ac_relay_in = 1'b0;
            dc_relay_in = 1'b0;
            ac_stamp_in = now_s4_ff;
            dc_stamp_in = now_s4_ff;
         end
      end
   end

   // Channel state advances with each delivered tick
   always_ff @(posedge clock) begin
      if (reset) begin
         ac_relay_ff <= 1'b0;
         dc_relay_ff <= 1'b0;
         ac_stamp_ff <= '0;
         dc_stamp_ff <= '0;
      end else if (adv_o) begin
         ac_relay_ff <= ac_relay_in;
         dc_relay_ff <= dc_relay_in;
         ac_stamp_ff <= ac_stamp_in;
         dc_stamp_ff <= dc_stamp_in;
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (adv_o) begin
         ac_on_ff   <= ac_relay_in;
         dc_on_ff   <= dc_relay_in;
         mv_out_ff  <= mv_s4;
         ac_load_ff <= ac_load_in;
         dc_load_ff <= dc_load_in;
         status_ff  <= status_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {5'b0, status_ff, dc_load_ff, ac_load_ff, mv_out_ff,
                        dc_on_ff, ac_on_ff};

   // A closed relay is always an armed channel
   a_closed_armed: assert property (@(posedge clock) disable iff (reset)
      (!ac_relay_ff || ac_stamp_ff == '0) && (!dc_relay_ff || dc_stamp_ff == '0))
      else $error("closed relay with a pending trip stamp");

   // Delivered relay flags match the state they leave behind
   a_state_out: assert property (@(posedge clock) disable iff (reset)
      adv_o |=> (ac_relay_ff == ac_on_ff) && (dc_relay_ff == dc_on_ff))
      else $error("relay state and result disagree");

   // Undervoltage cut opens both relays
   a_underv_open: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && status_ff == STATUS_UNDERV) |-> (!ac_on_ff && !dc_on_ff))
      else $error("undervoltage result with a closed relay");

   // No load is reported outside the normal pass
   a_load_zero: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && status_ff != STATUS_NORMAL) |->
      (ac_load_ff == '0 && dc_load_ff == '0))
      else $error("load reported during cut or hold");

   // Input stalls only with every stage occupied
   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (v1_ff && v2_ff && v3_ff && v4_ff && out_valid_ff))
      else $error("input stalled with an empty stage");

endmodule

// ===== test/battery_load_protection_tb.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// battery_load_protection_tb: self-checking bench for the load protection block
// A short table of hand-picked ticks covers reset state, undervoltage cut,
// recovery wait, trips, re-arm, time wrap and the current floor. Random ticks
// follow in phases with different thresholds and idle patterns on both streams.
// Results are checked against typed rows or a local model of relays and stamps.
// ---------------------------------------------------------------------------
module battery_load_protection_tb;
   import blp_pkg::*;

   localparam int NUM_REGS     = CSR_NOISE + 1;
   localparam int RANDOM_PHASE = 84;
   localparam int DRAIN_CYCLES = 20;

   // One tick, laid out as on req_tdata (last member in the lowest bits)
   typedef struct packed {
      logic [TIME_W-1:0]       now_ms;
      logic signed [RAW_W-1:0] dc_raw;
      logic signed [RAW_W-1:0] ac_raw;
      logic [ADC_W-1:0]        adc_d;
      logic [ADC_W-1:0]        adc_c;
      logic [ADC_W-1:0]        adc_b;
      logic [ADC_W-1:0]        adc_a;
   } tick_type;

   // One result, laid out as on rsp_tdata
   typedef struct packed {
      logic [1:0]        status;
      logic [LOAD_W-1:0] dc_load;
      logic [LOAD_W-1:0] ac_load;
      logic [MV_W-1:0]   battery_mv;
      logic              dc_on;
      logic              ac_on;
   } outcome_type;

   // Row of the hand-written table; typed marks rows with a fixed expectation
   typedef struct {
      logic [ADC_W-1:0]  a, b, c, d;
      logic [RAW_W-1:0]  ac, dc;
      logic [TIME_W-1:0] now;
      bit                typed;
      logic              ac_on, dc_on;
      logic [MV_W-1:0]   mv;
      logic [LOAD_W-1:0] ac_ld, dc_ld;
      logic [1:0]        st;
   } vector_type;

   localparam int NUM_VECTORS = 19;

   vector_type directed_ticks [NUM_VECTORS] = '{
      // after reset: relays open, battery flat -> wait for recovery
      '{0, 0, 0, 0, 0, 0, 1, 1, 0, 0, 100, 0, 0, STATUS_HOLD},
      // full battery: both channels close
      '{1023, 1023, 1023, 1023, 0, 0, 10, 1, 1, 1, 25100, 0, 0, STATUS_NORMAL},
      // undervoltage with both relays closed
      '{0, 0, 0, 0, 0, 0, 20, 1, 0, 0, 100, 0, 0, STATUS_UNDERV},
      '{0, 0, 0, 0, 0, 0, 30, 1, 0, 0, 100, 0, 0, STATUS_HOLD},
      // max AC current: AC trip and combined trip
      '{1023, 1023, 1023, 1023, 18'h1FFFF, 0, 40, 0, 0, 0, 0, 0, 0, STATUS_NORMAL},
      // tripped channels ignore their current
      '{1023, 1023, 1023, 1023, 18'h1FFFF, 18'h1FFFF, 50, 0, 0, 0, 0, 0, 0,
        STATUS_NORMAL},
      // retry delay elapsed exactly
      '{1023, 1023, 1023, 1023, 0, 0, 5040, 0, 0, 0, 0, 0, 0, STATUS_NORMAL},
      // most negative and minus one
      '{1023, 1023, 1023, 1023, 18'h20000, 18'h3FFFF, 5041, 0, 0, 0, 0, 0, 0,
        STATUS_NORMAL},
      // just above and at the noise floor
      '{1023, 1023, 1023, 1023, 901, 900, 5042, 0, 0, 0, 0, 0, 0, STATUS_NORMAL},
      // DC trip stamped at time zero stays armed
      '{1023, 1023, 1023, 1023, 0, 45003, 0, 0, 0, 0, 0, 0, 0, STATUS_NORMAL},
      '{1023, 1023, 1023, 1023, 0, 45003, 6000, 0, 0, 0, 0, 0, 0, STATUS_NORMAL},
      // AC trips at the top of time and DC stamp clears; AC waits across the wrap
      '{1023, 1023, 1023, 1023, 84003, 0, 32'hFFFFFFFF, 0, 0, 0, 0, 0, 0,
        STATUS_NORMAL},
      '{1023, 1023, 1023, 1023, 0, 0, 2, 0, 0, 0, 0, 0, 0, STATUS_NORMAL},
      // just below cutoff with one relay open
      '{401, 401, 401, 401, 0, 0, 3, 0, 0, 0, 0, 0, 0, STATUS_NORMAL},
      // alternating bit patterns
      '{10'h2AA, 10'h155, 10'h2AA, 10'h155, 18'h2AAAA, 18'h15555, 32'hAAAAAAAA,
        0, 0, 0, 0, 0, 0, STATUS_NORMAL},
      '{10'h155, 10'h2AA, 10'h155, 10'h2AA, 18'h15555, 18'h2AAAA, 32'h55555555,
        0, 0, 0, 0, 0, 0, STATUS_NORMAL},
      // AC exactly at its limit
      '{1023, 1023, 1023, 1023, 84000, 0, 32'h55560000, 0, 0, 0, 0, 0, 0,
        STATUS_NORMAL},
      // combined current exactly at the total limit
      '{1023, 1023, 1023, 1023, 60000, 30000, 32'h55570000, 0, 0, 0, 0, 0, 0,
        STATUS_NORMAL},
      '{1023, 1023, 1023, 1023, 0, 0, 32'h55580000, 0, 0, 0, 0, 0, 0,
        STATUS_NORMAL}
   };

   // Kinds of threshold sets used by the random phases
   typedef enum int {PLAN_DEFAULT, PLAN_ZERO, PLAN_MAX, PLAN_RANDOM} plan_kind_type;

   plan_kind_type phase_plan [6] = '{PLAN_RANDOM, PLAN_ZERO, PLAN_RANDOM,
                                     PLAN_MAX, PLAN_RANDOM, PLAN_DEFAULT};

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [111:0]          req_tdata = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [55:0]           rsp_tdata;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   // Local copy of thresholds, relays and trip stamps
   logic [CSR_DATA_W-1:0] threshold [NUM_REGS];
   logic [CSR_DATA_W-1:0] next_thresholds [NUM_REGS];
   logic                  ac_closed, dc_closed;
   logic [TIME_W-1:0]     ac_tripped_at, dc_tripped_at;

   outcome_type       pending_results [$];
   outcome_type       want, got;
   int                mismatch_count = 0;
   int                send_idle_pct = 37;
   int                recv_idle_pct = 53;
   logic [TIME_W-1:0] clock_ms = '0;

   battery_load_protection DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Register write as the block stores it
   function automatic void set_threshold(logic [CSR_IDX_W-1:0] idx,
                                         logic [CSR_DATA_W-1:0] value);
      case (idx)
         CSR_CUTOFF, CSR_RECOVERY: threshold[idx] = value & 17'h07FFF;
         CSR_RETRY:                threshold[idx] = value & 17'h0FFFF;
         default:                  threshold[idx] = value;
      endcase
   endfunction

   // Raw current above the floor counts, divided by 3
   function automatic logic [LOAD_W-1:0] condition_load(logic signed [RAW_W-1:0] raw);
      int level;
      level = int'(raw);
      if (level > int'(threshold[CSR_NOISE])) return LOAD_W'(level / 3);
      return '0;
   endfunction

   // Protection decision for one tick; updates relays and stamps
   function automatic outcome_type protect_tick(tick_type t);
      outcome_type       r;
      int unsigned       adc_sum, volts;
      logic [TIME_W-1:0] elapsed;
      r = '0;
      adc_sum = 32'(t.adc_a) + 32'(t.adc_b) + 32'(t.adc_c) + 32'(t.adc_d);
      volts = adc_sum * MV_SCALE / (NUM_ADC * ADC_FULL) + MV_OFFSET;
      r.battery_mv = MV_W'(volts);
      if (ac_closed && dc_closed && volts <= threshold[CSR_CUTOFF]) begin
         ac_closed = 1'b0;
         dc_closed = 1'b0;
         r.status  = STATUS_UNDERV;
      end else if (!(ac_closed && dc_closed) && volts < threshold[CSR_RECOVERY]) begin
         r.status = STATUS_HOLD;
      end else begin
         r.status = STATUS_NORMAL;
         if (ac_tripped_at == '0) begin
            ac_closed = 1'b1;
            r.ac_load = condition_load(t.ac_raw);
            if (r.ac_load > threshold[CSR_AC_LIMIT]) begin
               ac_closed     = 1'b0;
               ac_tripped_at = t.now_ms;
            end
         end
         if (dc_tripped_at == '0) begin
            dc_closed = 1'b1;
            r.dc_load = condition_load(t.dc_raw);
            if (r.dc_load > threshold[CSR_DC_LIMIT]) begin
               dc_closed     = 1'b0;
               dc_tripped_at = t.now_ms;
            end
         end
         // re-arm once the retry delay has passed, modulo 2^32
         elapsed = t.now_ms - ac_tripped_at;
         if (!ac_closed && elapsed >= threshold[CSR_RETRY]) ac_tripped_at = '0;
         elapsed = t.now_ms - dc_tripped_at;
         if (!dc_closed && elapsed >= threshold[CSR_RETRY]) dc_tripped_at = '0;
         // combined overload trips both
         if (17'(r.ac_load) + 17'(r.dc_load) >= threshold[CSR_TOTAL]) begin
            ac_closed     = 1'b0;
            dc_closed     = 1'b0;
            ac_tripped_at = t.now_ms;
            dc_tripped_at = t.now_ms;
         end
      end
      r.ac_on = ac_closed;
      r.dc_on = dc_closed;
      return r;
   endfunction

   function automatic logic [RAW_W-1:0] random_current();
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 45) return RAW_W'($urandom_range(0, 60000));
      if (pick < 65) return RAW_W'($urandom_range(0, 3000));
      if (pick < 80) return RAW_W'($urandom_range(40000, 100000));
      return RAW_W'($urandom);
   endfunction

   // Mostly a healthy battery and a slowly advancing clock
   function automatic tick_type random_tick();
      tick_type    t;
      int unsigned pick, lo, hi;
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
         lo = 500;
         hi = 1023;
      end else if (pick < 85) begin
         lo = 0;
         hi = 1023;
      end else begin
         lo = 0;
         hi = 400;
      end
      t.adc_a  = ADC_W'($urandom_range(lo, hi));
      t.adc_b  = ADC_W'($urandom_range(lo, hi));
      t.adc_c  = ADC_W'($urandom_range(lo, hi));
      t.adc_d  = ADC_W'($urandom_range(lo, hi));
      t.ac_raw = random_current();
      t.dc_raw = random_current();
      pick = $urandom_range(0, 99);
      if (pick < 88)      clock_ms = clock_ms + $urandom_range(1, 400);
      else if (pick < 95) clock_ms = clock_ms + $urandom_range(1000, 70000);
      else if (pick < 99) clock_ms = $urandom;
      else                clock_ms = '0;
      t.now_ms = clock_ms;
      return t;
   endfunction

   function automatic void load_plan(plan_kind_type kind);
      int unsigned cut;
      case (kind)
         PLAN_DEFAULT: begin
            next_thresholds[CSR_CUTOFF]   = CSR_DATA_W'(CUTOFF_RST);
            next_thresholds[CSR_RECOVERY] = CSR_DATA_W'(RECOVERY_RST);
            next_thresholds[CSR_AC_LIMIT] = AC_LIMIT_RST;
            next_thresholds[CSR_DC_LIMIT] = DC_LIMIT_RST;
            next_thresholds[CSR_TOTAL]    = TOTAL_RST;
            next_thresholds[CSR_RETRY]    = CSR_DATA_W'(RETRY_RST);
            next_thresholds[CSR_NOISE]    = NOISE_RST;
         end
         PLAN_ZERO: foreach (next_thresholds[i]) next_thresholds[i] = '0;
         // upper bits beyond the register width are dropped by the block
         PLAN_MAX:  foreach (next_thresholds[i]) next_thresholds[i] = '1;
         default: begin
            cut = $urandom_range(8000, 14000);
            next_thresholds[CSR_CUTOFF]   = CSR_DATA_W'(cut);
            next_thresholds[CSR_RECOVERY] = CSR_DATA_W'(cut + $urandom_range(0, 4000));
            next_thresholds[CSR_AC_LIMIT] = CSR_DATA_W'($urandom_range(0, 40000));
            next_thresholds[CSR_DC_LIMIT] = CSR_DATA_W'($urandom_range(0, 30000));
            next_thresholds[CSR_TOTAL]    = CSR_DATA_W'($urandom_range(0, 60000));
            next_thresholds[CSR_RETRY]    = CSR_DATA_W'($urandom_range(0, 1500));
            next_thresholds[CSR_NOISE]    = CSR_DATA_W'($urandom_range(0, 3000));
         end
      endcase
   endfunction

   // Called at a falling edge; returns at the falling edge after acceptance
   task automatic send_tick(input tick_type t, input bit typed, input outcome_type fixed);
      outcome_type predicted;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= 112'(t);
      do @(posedge clock); while (!req_tready);
      predicted = protect_tick(t);
      pending_results.push_back(typed ? fixed : predicted);
      @(negedge clock);
   endtask

   // Writes all thresholds once no tick is in flight
   task automatic write_thresholds();
      while (pending_results.size() != 0) @(posedge clock);
      @(negedge clock);
      for (int r = CSR_CUTOFF; r <= CSR_NOISE; r++) begin
         csr_valid <= 1'b1;
         csr_index <= CSR_IDX_W'(r);
         csr_data  <= next_thresholds[r];
         do @(posedge clock); while (!csr_ready);
         set_threshold(CSR_IDX_W'(r), next_thresholds[r]);
         @(negedge clock);
      end
      csr_valid <= 1'b0;
   endtask

   function automatic void check_field(string name, int unsigned expected,
                                       int unsigned actual);
      if (expected != actual) begin
         $error("%s: expected %0d, got %0d", name, expected, actual);
         mismatch_count++;
      end
   endfunction

   // Result side back-pressure
   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
   end

   // Result checker
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_results.size() == 0) begin
            $error("result with nothing expected: %h", rsp_tdata);
            mismatch_count++;
         end else begin
            want = pending_results.pop_front();
            got  = outcome_type'(rsp_tdata[$bits(outcome_type)-1:0]);
            check_field("ac_on", 32'(want.ac_on), 32'(got.ac_on));
            check_field("dc_on", 32'(want.dc_on), 32'(got.dc_on));
            check_field("battery_mv", 32'(want.battery_mv), 32'(got.battery_mv));
            check_field("ac_load_ma", 32'(want.ac_load), 32'(got.ac_load));
            check_field("dc_load_ma", 32'(want.dc_load), 32'(got.dc_load));
            check_field("tick_status", 32'(want.status), 32'(got.status));
         end
      end
   end

   // Stimulus
   initial begin
      tick_type    t;
      outcome_type fixed;
      set_threshold(CSR_CUTOFF, CSR_DATA_W'(CUTOFF_RST));
      set_threshold(CSR_RECOVERY, CSR_DATA_W'(RECOVERY_RST));
      set_threshold(CSR_AC_LIMIT, AC_LIMIT_RST);
      set_threshold(CSR_DC_LIMIT, DC_LIMIT_RST);
      set_threshold(CSR_TOTAL, TOTAL_RST);
      set_threshold(CSR_RETRY, CSR_DATA_W'(RETRY_RST));
      set_threshold(CSR_NOISE, NOISE_RST);
      ac_closed     = 1'b0;
      dc_closed     = 1'b0;
      ac_tripped_at = '0;
      dc_tripped_at = '0;

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // hand-picked ticks at reset thresholds
      foreach (directed_ticks[i]) begin
         t.adc_a        = directed_ticks[i].a;
         t.adc_b        = directed_ticks[i].b;
         t.adc_c        = directed_ticks[i].c;
         t.adc_d        = directed_ticks[i].d;
         t.ac_raw       = directed_ticks[i].ac;
         t.dc_raw       = directed_ticks[i].dc;
         t.now_ms       = directed_ticks[i].now;
         fixed.ac_on      = directed_ticks[i].ac_on;
         fixed.dc_on      = directed_ticks[i].dc_on;
         fixed.battery_mv = directed_ticks[i].mv;
         fixed.ac_load    = directed_ticks[i].ac_ld;
         fixed.dc_load    = directed_ticks[i].dc_ld;
         fixed.status     = directed_ticks[i].st;
         send_tick(t, directed_ticks[i].typed, fixed);
      end
      req_tvalid <= 1'b0;
      clock_ms = 32'h55580000;

      // random phases: two per idle pattern, new thresholds each
      foreach (phase_plan[p]) begin
         case (p / 2)
            0: begin
               send_idle_pct = 37;
               recv_idle_pct = 53;
            end
            1: begin
               send_idle_pct = 53;
               recv_idle_pct = 37;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         load_plan(phase_plan[p]);
         write_thresholds();
         repeat (RANDOM_PHASE) send_tick(random_tick(), 1'b0, '0);
         req_tvalid <= 1'b0;
      end

      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #400000;
      $display("CHECKS FAILED");
      $finish;
   end

endmodule
